FILE: hw/rtl/hrde_pkg.sv
// ----------------------------------------------------------------------------
// hrde_pkg
// Types and constants shared by the hex record dump encoder modules.
// ----------------------------------------------------------------------------
package hrde_pkg;

    localparam int STORE_DEPTH = 16;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] EXT_LEN  = 8'h02;
    localparam logic [7:0] EXT_TYPE = 8'h04;

    // byte slots inside a record body
    localparam logic [4:0] EXT_CHK_IDX = 5'd6;
    localparam logic [4:0] DATA_HDR    = 5'd4;

    localparam logic [3:0] EOF_LAST = 4'd11;

    localparam logic [7:0] EOF_TEXT [12] = '{
        8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
        8'h30, 8'h30, 8'h31, 8'h46, 8'h46, 8'h0A
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_EOF,
        S_EXT,
        S_DAT
    } t_state;

    typedef struct packed {
        t_state     st;
        logic [5:0] pos;
        logic       accept;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic op;
        logic emit_line;
        logic ext_next;
        logic rec_last;
    } t_sts;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/hrde_ctrl.sv
// ----------------------------------------------------------------------------
// hrde_ctrl
// Record sequencer: picks the record to write and steps its character slot.
// ----------------------------------------------------------------------------
module hrde_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hrde_pkg::t_sts i_sts,
    output hrde_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    hrde_pkg::t_state r_state;
    hrde_pkg::t_state n_state;
    logic [5:0]       r_pos;
    logic [5:0]       n_pos;
    logic             accept;
    logic             emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrde_pkg::S_IDLE;
            r_pos   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        unique case (r_state)
            hrde_pkg::S_IDLE: begin
                n_pos = 6'd0;
                if (accept) begin
                    if (i_sts.op) begin
                        n_state = hrde_pkg::S_EOF;
                    end else if (i_sts.emit_line) begin
                        n_state = i_sts.ext_next ? hrde_pkg::S_EXT : hrde_pkg::S_DAT;
                    end
                end
            end
            hrde_pkg::S_EOF, hrde_pkg::S_EXT, hrde_pkg::S_DAT: begin
                if (emit) begin
                    n_pos = r_pos + 6'd1;
                    if (i_sts.rec_last) begin
                        n_pos   = 6'd0;
                        n_state = (r_state == hrde_pkg::S_EXT) ? hrde_pkg::S_DAT
                                                               : hrde_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = hrde_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        accept = 1'b0;
        emit   = 1'b0;
        unique case (r_state)
            hrde_pkg::S_IDLE: begin
                accept = i_in_valid && i_rst_n;
            end
            hrde_pkg::S_EOF, hrde_pkg::S_EXT, hrde_pkg::S_DAT: begin
                emit = i_sts.out_free;
            end
            default: begin
                accept = 1'b0;
            end
        endcase
    end

    assign o_in_stall    = !i_rst_n || (r_state != hrde_pkg::S_IDLE);
    assign o_cmd.st      = r_state;
    assign o_cmd.pos     = r_pos;
    assign o_cmd.accept  = accept;
    assign o_cmd.emit    = emit;

endmodule

FILE: hw/rtl/hrde_dp.sv
// ----------------------------------------------------------------------------
// hrde_dp
// Line store, fill count, line address, checksum and character output stage.
// ----------------------------------------------------------------------------
module hrde_dp #(
    parameter int BYTES_PER_LINE = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hrde_pkg::t_cmd i_cmd,
    output hrde_pkg::t_sts o_sts,
    input  logic           i_op,
    input  logic [7:0]     i_data_byte,
    input  logic [31:0]    i_start_address,
    input  logic           i_first_of_block,
    input  logic           i_last_of_block,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_text_char,
    output logic           o_run_end
);

    logic [7:0]  r_line_store [hrde_pkg::STORE_DEPTH];
    logic [7:0]  r_rd_byte;
    logic [4:0]  r_fill;
    logic [4:0]  n_fill;
    logic [31:0] r_addr;
    logic [31:0] n_addr;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic        r_out_valid;
    logic [7:0]  r_text_char;
    logic        r_run_end;

    logic        take_byte;
    logic [4:0]  fill_base;
    logic [4:0]  fill_nx;
    logic [5:0]  pm1;
    logic [4:0]  k;
    logic [4:0]  rec_end;
    logic [5:0]  nx_pos;
    logic [5:0]  nx_pm1;
    logic [3:0]  rd_idx;
    logic [7:0]  chk;
    logic [7:0]  byte_val;
    logic [3:0]  nib;
    logic [7:0]  ch;
    logic        last;

    assign take_byte = i_cmd.accept && !i_op;
    assign fill_base = i_first_of_block ? 5'd0 : r_fill;
    assign fill_nx   = fill_base + 5'd1;

    // store slot of the slot that is current on the next cycle
    assign nx_pos = i_cmd.emit ? (i_cmd.pos + 6'd1) : i_cmd.pos;
    assign nx_pm1 = nx_pos - 6'd1;
    assign rd_idx = nx_pm1[4:1] - hrde_pkg::DATA_HDR[3:0];

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.op        = i_op;
    assign o_sts.emit_line = (fill_nx == 5'(BYTES_PER_LINE)) || i_last_of_block;
    assign o_sts.ext_next  = i_first_of_block ? (i_start_address[15:0] == 16'd0)
                                              : (r_addr[15:0] == 16'd0);
    assign o_sts.rec_last  = last;

    // character of the current slot
    always_comb begin
        pm1      = i_cmd.pos - 6'd1;
        k        = pm1[5:1];
        rec_end  = (i_cmd.st == hrde_pkg::S_EXT) ? hrde_pkg::EXT_CHK_IDX
                                                 : hrde_pkg::DATA_HDR + r_fill;
        chk      = 8'd0 - r_sum;
        byte_val = chk;
        if (i_cmd.st == hrde_pkg::S_EXT) begin
            case (k)
                5'd0:       byte_val = hrde_pkg::EXT_LEN;
                5'd1, 5'd2: byte_val = 8'h00;
                5'd3:       byte_val = hrde_pkg::EXT_TYPE;
                5'd4:       byte_val = r_addr[31:24];
                5'd5:       byte_val = r_addr[23:16];
                default:    byte_val = chk;
            endcase
        end else begin
            case (k)
                5'd0:    byte_val = {3'd0, r_fill};
                5'd1:    byte_val = r_addr[15:8];
                5'd2:    byte_val = r_addr[7:0];
                5'd3:    byte_val = 8'h00;
                default: byte_val = (k < rec_end) ? r_rd_byte : chk;
            endcase
        end
        nib  = pm1[0] ? byte_val[3:0] : byte_val[7:4];
        last = 1'b0;
        if (i_cmd.st == hrde_pkg::S_EOF) begin
            ch   = hrde_pkg::EOF_TEXT[i_cmd.pos[3:0]];
            last = (i_cmd.pos[3:0] == hrde_pkg::EOF_LAST);
        end else if (i_cmd.pos == 6'd0) begin
            ch = hrde_pkg::CH_COLON;
        end else if (k == rec_end + 5'd1) begin
            ch   = hrde_pkg::CH_LF;
            last = 1'b1;
        end else begin
            ch = hrde_pkg::hex_char(nib);
        end
    end

    // line state and running checksum
    always_comb begin
        n_fill = r_fill;
        n_addr = r_addr;
        n_sum  = r_sum;
        if (take_byte) begin
            n_fill = fill_nx;
            if (i_first_of_block) begin
                n_addr = i_start_address;
            end
        end
        if (i_cmd.emit && i_cmd.st != hrde_pkg::S_EOF) begin
            if (i_cmd.pos == 6'd0) begin
                n_sum = 8'd0;
            end else if (!pm1[0] && k < rec_end) begin
                n_sum = r_sum + byte_val;
            end
            if (i_cmd.st == hrde_pkg::S_DAT && last) begin
                n_addr = r_addr + {27'd0, r_fill};
                n_fill = 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 5'd0;
            r_addr      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_addr <= n_addr;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_rd_byte <= r_line_store[rd_idx];
        if (take_byte) begin
            r_line_store[fill_base[3:0]] <= i_data_byte;
        end
        if (i_cmd.emit) begin
            r_text_char <= ch;
            r_run_end   <= last && (i_cmd.st != hrde_pkg::S_EXT);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_text_char;
    assign o_run_end   = r_run_end;

endmodule

FILE: hw/rtl/hex_record_dump_encoder_top.sv
// ----------------------------------------------------------------------------
// hex_record_dump_encoder_top
// Turns a stream of memory bytes into hex record text, one character a
// transaction.
//
//   channel | direction | handshake                  | payload
//   input   | in        | i_in_valid / o_in_stall    | op, data_byte, start_address,
//           |           |                            | first_of_block, last_of_block
//   output  | out       | o_out_valid / i_out_stall  | text_char, run_end
//
// a byte that does not close a line is taken while the sequencer stays idle;
// a closing byte is taken, then the record sequencer writes an extended address
// record if the low address half is zero, then the data record, one character
// per step while the output is free; the end-of-file op writes its 12 characters
// input is stalled in reset and while a record is being written; the output
// register lets the next input in while its last character waits
// synchronous active-low reset; output stall holds the sequencer in place
// ----------------------------------------------------------------------------
module hex_record_dump_encoder_top #(
    parameter int BYTES_PER_LINE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_start_address,
    input  logic        i_first_of_block,
    input  logic        i_last_of_block,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_text_char,
    output logic        o_run_end
);

    hrde_pkg::t_cmd cmd;
    hrde_pkg::t_sts sts;

    hrde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    hrde_dp #(
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .i_start_address  (i_start_address),
        .i_first_of_block (i_first_of_block),
        .i_last_of_block  (i_last_of_block),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_text_char      (o_text_char),
        .o_run_end        (o_run_end)
    );

endmodule

FILE: hw/rtl/hrde_chk.sv
// ----------------------------------------------------------------------------
// hrde_chk
// Port-level checks of the hex record dump encoder.
// ----------------------------------------------------------------------------
module hrde_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_op,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_text_char,
    input logic        o_run_end
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_text_char)
            && $stable(o_run_end))
        else $error("output changed while stalled");

    // every run ends on a linefeed
    a_run_end_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_end |-> o_text_char == 8'h0A)
        else $error("run end not on linefeed");

    // only record text characters
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_text_char >= 8'h30 && o_text_char <= 8'h39)
            || (o_text_char >= 8'h41 && o_text_char <= 8'h46)
            || o_text_char == 8'h3A || o_text_char == 8'h0A)
        else $error("illegal record character");

    // end-of-file op always starts a record, blocking input
    a_eof_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op |=> o_in_stall)
        else $error("input open right after end-of-file op");

endmodule

bind hex_record_dump_encoder_top hrde_chk u_hrde_chk (.*);
